// ----- rtl/core/bsa_pkg.sv -----
// Package for the bitmap slot allocator: map geometry, codes, shared types
// and the lowest-set-bit finder. No dependencies.
`default_nettype none

package bsa_pkg;

    localparam int MAX_SLOTS = 256;
    localparam int WORD_BITS = 32;
    localparam int MAP_WORDS = 8;
    localparam int CAP_SLOTS = (MAP_WORDS * WORD_BITS < MAX_SLOTS) ?
                               MAP_WORDS * WORD_BITS : MAX_SLOTS;

    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int WIDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SLOT_W = 8;
    localparam int CNT_W  = 9;
    localparam int OP_W   = 2;
    localparam int ST_W   = 3;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [BIT_W-1:0]     t_bidx;
    typedef logic [WIDX_W-1:0]    t_widx;
    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [CNT_W-1:0]     t_cnt;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_RESERVE = 2'd2
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 3'd0,
        ST_RANGE = 3'd1,
        ST_CLEAR = 3'd2,
        ST_SET   = 3'd3,
        ST_FULL  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_WRITE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic  found;
        t_bidx idx;
    } t_find;

    typedef struct packed {
        logic  tgt;
        logic  chg;
        logic  free_found;
        t_bidx free_bit;
        logic  used_found;
        t_bidx used_bit;
        t_word mod_data;
    } t_eval;

    function automatic t_find find_low(input t_word v);
        t_find r;
        r.found = 1'b0;
        r.idx   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r.found = 1'b1;
                r.idx   = t_bidx'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bsa_req_if.sv -----
// Request channel of the slot allocator: valid/ready plus one item.
// Depends on bsa_pkg.
`default_nettype none

interface bsa_req_if;
    import bsa_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [SLOT_W-1:0] slot_index;

    modport source (output valid, operation, slot_index, input ready);
    modport sink   (input valid, operation, slot_index, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bsa_rsp_if.sv -----
// Result channel of the slot allocator: valid/ready plus one item.
// Depends on bsa_pkg.
`default_nettype none

interface bsa_rsp_if;
    import bsa_pkg::*;

    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [SLOT_W-1:0] granted_index;
    logic              any_used;
    logic [SLOT_W-1:0] lowest_used;

    modport source (output valid, status, granted_index, any_used, lowest_used,
                    input ready);
    modport sink   (input valid, status, granted_index, any_used, lowest_used,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bsa_word_eval.sv -----
// Shared per-word unit: masks one map word to the live slot range, applies a
// pending free/reserve, and finds the lowest free and lowest used bit.
// Depends on bsa_pkg.
`default_nettype none

module bsa_word_eval (
    input  var bsa_pkg::t_word          i_data,
    input  var bsa_pkg::t_widx          i_word,
    input  var logic [bsa_pkg::OP_W-1:0] i_op,
    input  var bsa_pkg::t_slot          i_idx,
    input  var bsa_pkg::t_cnt           i_num,
    input  var logic                    i_apply,
    output bsa_pkg::t_eval              o_eval
);
    import bsa_pkg::*;

    t_cnt  base;
    t_word mask;
    t_word bit_m;
    logic  tgt;
    logic  tbit;
    logic  want;
    logic  rw;
    logic  chg;
    t_word mod_data;
    t_find f_free;
    t_find f_used;

    always_comb begin
        base = t_cnt'(i_word) << BIT_W;
        if (i_num >= base + t_cnt'(WORD_BITS)) begin
            mask = '1;
        end else if (i_num <= base) begin
            mask = '0;
        end else begin
            mask = (t_word'(1) << i_num[BIT_W-1:0]) - t_word'(1);
        end

        bit_m = t_word'(1) << i_idx[BIT_W-1:0];
        tgt   = (t_widx'(i_idx >> BIT_W) == i_word);
        tbit  = i_data[i_idx[BIT_W-1:0]];
        want  = (i_op == OP_RESERVE);
        rw    = (i_op == OP_FREE) || (i_op == OP_RESERVE);
        chg   = i_apply && rw && tgt && (tbit != want);

        if (!chg) begin
            mod_data = i_data;
        end else if (want) begin
            mod_data = i_data | bit_m;
        end else begin
            mod_data = i_data & ~bit_m;
        end

        f_free = find_low(~i_data & mask);
        f_used = find_low(mod_data & mask);

        o_eval.tgt        = tgt && rw;
        o_eval.chg        = chg;
        o_eval.free_found = f_free.found;
        o_eval.free_bit   = f_free.idx;
        o_eval.used_found = f_used.found;
        o_eval.used_bit   = f_used.idx;
        o_eval.mod_data   = mod_data;
    end

endmodule

`default_nettype wire

// ----- rtl/core/bitmap_slot_allocator.sv -----
// Bitmap slot allocator: used-slot map in a word memory, scanned word by word
// through bsa_word_eval. Depends on bsa_pkg, bsa_req_if, bsa_rsp_if.
//
// Channels: i_req carries an operation (allocate, free, reserve) and a slot
// index; o_rsp returns status, granted slot, any-used flag and lowest used
// slot. Both are valid/ready; an item moves when valid and ready are high.
// i_cfg_we/i_cfg_data write num_slots; write it only while the block is idle.
//
// A request passes through S_SCAN, S_DRAIN, S_WRITE and S_OUT before its result is valid.
// Every request scans all 8 map words, one per cycle through the single
// memory read port and the shared word unit, then writes back at most one word.
// i_req.ready is high only when idle, so no new request is taken while one is in work.
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver stalls, the following item waits before its
// result is loaded, and the block stops taking new requests.
//
// Reset: the map reads as all free (per-word valid bits are cleared), and
// num_slots returns to 256. No clearing pass is needed.
`default_nettype none

module bitmap_slot_allocator (
    input  var logic                     i_clk,
    input  var logic                     i_rst_n,
    bsa_req_if.sink                      i_req,
    bsa_rsp_if.source                    o_rsp,
    input  var logic                     i_cfg_we,
    input  var logic [bsa_pkg::CNT_W-1:0] i_cfg_data
);
    import bsa_pkg::*;

    t_state r_state, n_state;

    t_cnt             r_num_slots;
    t_cnt             r_n;
    logic [OP_W-1:0]  r_op;
    t_slot            r_idx;
    logic [ST_W-1:0]  r_status;

    t_word r_mem [MAP_WORDS];
    logic  [MAP_WORDS-1:0] r_wvld;
    t_word r_rd_data;
    logic  r_rd_vld;
    t_widx r_raddr;
    t_widx r_eval_w;
    logic  r_pend;

    logic  r_free_found;
    t_slot r_free_slot;
    t_word r_free_data;
    logic  r_used_found;
    t_slot r_used_slot;
    logic  r_wr_en;
    t_word r_wr_data;

    logic [ST_W-1:0] r_res_status;
    t_slot           r_res_grant;
    logic            r_res_any;
    t_slot           r_res_low;

    logic            r_out_vld;
    logic [ST_W-1:0] r_out_status;
    t_slot           r_out_grant;
    logic            r_out_any;
    t_slot           r_out_low;

    t_eval ev;
    t_word ev_data;
    t_cnt  n_eff;
    logic  accept;
    logic  rd_go;
    logic  wr_go;
    logic  out_load;
    logic  is_rw;
    t_widx wr_addr;
    t_word wr_data;
    logic  wr_en;

    assign accept  = i_req.valid && i_req.ready;
    assign ev_data = r_rd_vld ? r_rd_data : '0;
    assign n_eff   = (r_num_slots > t_cnt'(CAP_SLOTS)) ? t_cnt'(CAP_SLOTS) : r_num_slots;
    assign is_rw   = (r_op == OP_FREE) || (r_op == OP_RESERVE);

    bsa_word_eval u_eval (
        .i_data  (ev_data),
        .i_word  (r_eval_w),
        .i_op    (r_op),
        .i_idx   (r_idx),
        .i_num   (r_n),
        .i_apply (r_status == ST_OK),
        .o_eval  (ev)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_raddr == t_widx'(MAP_WORDS - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_WRITE;
            S_WRITE: n_state = S_OUT;
            S_OUT: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_req.ready = 1'b0;
        rd_go       = 1'b0;
        wr_go       = 1'b0;
        out_load    = 1'b0;
        case (r_state)
            S_IDLE:  i_req.ready = 1'b1;
            S_SCAN:  rd_go = 1'b1;
            S_DRAIN: ;
            S_WRITE: wr_go = 1'b1;
            S_OUT:   out_load = !r_out_vld || o_rsp.ready;
            default: ;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = t_widx'(r_idx >> BIT_W);
        wr_data = r_wr_data;
        if (wr_go) begin
            if (r_op == OP_ALLOC && r_free_found) begin
                wr_en   = 1'b1;
                wr_addr = t_widx'(r_free_slot >> BIT_W);
                wr_data = r_free_data | (t_word'(1) << r_free_slot[BIT_W-1:0]);
            end else if (r_wr_en) begin
                wr_en = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num_slots <= t_cnt'(256);
            r_wvld      <= '0;
            r_pend      <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= rd_go;
            if (i_cfg_we) begin
                r_num_slots <= i_cfg_data;
            end
            if (wr_en) begin
                r_wvld[wr_addr] <= 1'b1;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // map memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[r_raddr];
        r_rd_vld  <= r_wvld[r_raddr];
        r_eval_w  <= r_raddr;
    end

    // request context and scan tracking
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op         <= i_req.operation;
            r_idx        <= i_req.slot_index;
            r_n          <= n_eff;
            r_raddr      <= '0;
            r_free_found <= 1'b0;
            r_used_found <= 1'b0;
            r_wr_en      <= 1'b0;
            r_free_slot  <= '0;
            r_used_slot  <= '0;
            if (i_req.operation == OP_ALLOC) begin
                r_status <= ST_OK;
            end else if ((i_req.operation == OP_FREE || i_req.operation == OP_RESERVE)
                         && ({1'b0, i_req.slot_index} < n_eff)) begin
                r_status <= ST_OK;
            end else begin
                r_status <= ST_RANGE;
            end
        end else begin
            if (rd_go) begin
                r_raddr <= r_raddr + t_widx'(1);
            end
            if (r_pend) begin
                if (!r_free_found && ev.free_found) begin
                    r_free_found <= 1'b1;
                    r_free_slot  <= t_slot'({r_eval_w, ev.free_bit});
                    r_free_data  <= ev_data;
                end
                if (!r_used_found && ev.used_found) begin
                    r_used_found <= 1'b1;
                    r_used_slot  <= t_slot'({r_eval_w, ev.used_bit});
                end
                if (ev.tgt && r_status == ST_OK) begin
                    if (ev.chg) begin
                        r_wr_en   <= 1'b1;
                        r_wr_data <= ev.mod_data;
                    end else if (r_op == OP_RESERVE) begin
                        r_status <= ST_SET;
                    end else begin
                        r_status <= ST_CLEAR;
                    end
                end
            end
        end
    end

    // result assembly
    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            if (r_op == OP_ALLOC && r_free_found) begin
                r_res_status <= ST_OK;
                r_res_grant  <= r_free_slot;
                r_res_any    <= 1'b1;
                r_res_low    <= (!r_used_found || r_free_slot < r_used_slot) ?
                                r_free_slot : r_used_slot;
            end else begin
                r_res_grant <= '0;
                r_res_any   <= r_used_found;
                r_res_low   <= r_used_found ? r_used_slot : '0;
                if (r_op == OP_ALLOC) begin
                    r_res_status <= ST_FULL;
                end else if (!is_rw) begin
                    r_res_status <= ST_RANGE;
                end else begin
                    r_res_status <= r_status;
                end
            end
        end
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_grant  <= r_res_grant;
            r_out_any    <= r_res_any;
            r_out_low    <= r_res_low;
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.granted_index = r_out_grant;
    assign o_rsp.any_used      = r_out_any;
    assign o_rsp.lowest_used   = r_out_low;

endmodule

`default_nettype wire

// ----- dv/bsa_alloc_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the bitmap slot allocator. It keeps its own used-slot map
// and slot count, predicts the report of each accepted request and compares.
// Depends on bsa_pkg, bsa_req_if and bsa_rsp_if.

module bsa_alloc_checker
    import bsa_pkg::*;
(
    input  var logic  i_clk,
    input  var logic  i_rst_n,
    bsa_req_if        i_req,
    bsa_rsp_if        i_rsp,
    input  var logic  i_cfg_we,
    input  var t_cnt  i_cfg_data,
    output int        o_fail_count,
    output int        o_report_count
);

    typedef struct packed {
        t_status status;
        t_slot   granted;
        logic    any_used;
        t_slot   lowest;
    } t_slot_report;

    logic [MAP_WORDS*WORD_BITS-1:0] used_bits;
    t_cnt                           slot_limit;
    t_slot_report                   due_reports[$];

    // Applies one request to the local map and returns the report it causes.
    function automatic t_slot_report apply_request(input logic [OP_W-1:0] op,
                                                   input t_slot idx);
        t_slot_report r;
        int           n;
        int           s;
        logic         want;
        n = (int'(slot_limit) < CAP_SLOTS) ? int'(slot_limit) : CAP_SLOTS;
        r.status   = ST_OK;
        r.granted  = '0;
        r.any_used = 1'b0;
        r.lowest   = '0;
        case (op)
            OP_ALLOC: begin
                r.status = ST_FULL;
                for (s = 0; s < n && r.status == ST_FULL; s++) begin
                    if (!used_bits[s]) begin
                        used_bits[s] = 1'b1;
                        r.status     = ST_OK;
                        r.granted    = t_slot'(s);
                    end
                end
            end
            OP_FREE, OP_RESERVE: begin
                want = (op == OP_RESERVE);
                if (int'(idx) >= n) begin
                    r.status = ST_RANGE;
                end else if (used_bits[idx] == want) begin
                    r.status = want ? ST_SET : ST_CLEAR;
                end else begin
                    used_bits[idx] = want;
                end
            end
            default: begin
                r.status = ST_RANGE;
            end
        endcase
        // bits at or above the slot count are kept but never reported
        for (s = n - 1; s >= 0; s--) begin
            if (used_bits[s]) begin
                r.any_used = 1'b1;
                r.lowest   = t_slot'(s);
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_slot_report exp_r;
        if (!i_rst_n) begin
            used_bits      = '0;
            slot_limit     = t_cnt'(MAX_SLOTS);
            due_reports.delete();
            o_fail_count   = 0;
            o_report_count = 0;
        end else begin
            if (i_cfg_we) begin
                slot_limit = i_cfg_data;
            end
            if (i_req.valid && i_req.ready) begin
                due_reports.push_back(apply_request(i_req.operation, i_req.slot_index));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                o_report_count++;
                if (due_reports.size() == 0) begin
                    $display("%0t: unexpected item: status=%0d granted=%0d any=%0d lowest=%0d",
                             $time, i_rsp.status, i_rsp.granted_index, i_rsp.any_used,
                             i_rsp.lowest_used);
                    o_fail_count++;
                end else begin
                    exp_r = due_reports.pop_front();
                    if (exp_r.status != i_rsp.status || exp_r.granted != i_rsp.granted_index ||
                        exp_r.any_used != i_rsp.any_used ||
                        exp_r.lowest != i_rsp.lowest_used) begin
                        $display("%0t: mismatch: expected status=%0d granted=%0d any=%0d %s%0d",
                                 $time, exp_r.status, exp_r.granted, exp_r.any_used,
                                 "lowest=", exp_r.lowest);
                        $display("%0t:           actual status=%0d granted=%0d any=%0d %s%0d",
                                 $time, i_rsp.status, i_rsp.granted_index, i_rsp.any_used,
                                 "lowest=", i_rsp.lowest_used);
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top for the bitmap slot allocator: clock, reset, slot-count writes,
// directed and random requests, random result stalls and the verdict.
// Depends on bsa_pkg, the channel interfaces and bsa_alloc_checker.

module tb_top;
    import bsa_pkg::*;

    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    t_cnt cfg_data;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    int   sent_count  = 0;
    int   slot_span   = CAP_SLOTS;
    int   fail_count;
    int   report_count;

    bsa_req_if req_ch();
    bsa_rsp_if rsp_ch();

    bitmap_slot_allocator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    bsa_alloc_checker u_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (req_ch),
        .i_rsp          (rsp_ch),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_report_count (report_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic send_req(input logic [OP_W-1:0] op, input t_slot idx);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_ch.valid      <= 1'b0;
            req_ch.operation  <= OP_W'($urandom_range(3));
            req_ch.slot_index <= t_slot'($urandom_range(255));
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= op;
        req_ch.slot_index <= idx;
        do @(posedge i_clk); while (!req_ch.ready);
        sent_count++;
    endtask

    // holds the sender until every outstanding item has come back
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (report_count < sent_count) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_limit(input t_cnt v);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        slot_span = (int'(v) > CAP_SLOTS) ? CAP_SLOTS : int'(v);
    endtask

    task automatic send_random();
        int    r;
        t_slot idx;
        r = $urandom_range(99);
        // mostly near the valid range, including one past the end
        if (slot_span > 0 && $urandom_range(3) != 0) begin
            idx = t_slot'($urandom_range(slot_span));
        end else begin
            idx = t_slot'($urandom_range(255));
        end
        if (r < 50) begin
            send_req(OP_ALLOC, idx);
        end else if (r < 75) begin
            send_req(OP_FREE, idx);
        end else begin
            send_req(OP_RESERVE, idx);
        end
    endtask

    task automatic run_random(input int n_items);
        int   done;
        t_cnt lim;
        done = 0;
        while (done < n_items) begin
            case ($urandom_range(9))
                0: lim = '0;
                1: lim = t_cnt'(1);
                2: lim = t_cnt'(CAP_SLOTS);
                3: lim = '1;
                4: lim = t_cnt'($urandom_range(41, 255));
                5: lim = t_cnt'($urandom_range(257, 511));
                default: lim = t_cnt'($urandom_range(2, 40));
            endcase
            write_limit(lim);
            repeat ($urandom_range(10, 40)) begin
                send_random();
                done++;
            end
        end
    endtask

    initial begin
        #5_000_000;
        $display("[bitmap_slot_allocator] ERROR");
        $finish;
    end

    initial begin
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_data          <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.operation  <= OP_ALLOC;
        req_ch.slot_index <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 8;
        rx_idle_pct = 80;

        // full slot count after reset
        send_req(OP_ALLOC, 8'hFF);
        send_req(OP_ALLOC, 8'h00);
        send_req(OP_RESERVE, 8'hFF);
        send_req(OP_RESERVE, 8'hFF);
        send_req(OP_FREE, 8'h00);
        send_req(OP_FREE, 8'h00);
        send_req(OP_ALLOC, 8'h00);
        send_req(OP_UNKNOWN, 8'h01);
        send_req(OP_FREE, 8'hFF);
        send_req(OP_RESERVE, 8'hAA);
        send_req(OP_RESERVE, 8'h55);
        // one slot: high bits kept but hidden
        write_limit(t_cnt'(1));
        send_req(OP_FREE, 8'h01);
        send_req(OP_ALLOC, 8'h00);
        send_req(OP_FREE, 8'h00);
        send_req(OP_ALLOC, 8'h00);
        // no slots at all
        write_limit('0);
        send_req(OP_ALLOC, 8'h00);
        send_req(OP_FREE, 8'h00);
        send_req(OP_RESERVE, 8'h00);
        send_req(OP_UNKNOWN, 8'h03);
        // count above capacity is capped
        write_limit('1);
        send_req(OP_ALLOC, 8'h00);
        send_req(OP_FREE, 8'hAA);

        run_random(80);

        tx_idle_pct = 80;
        rx_idle_pct = 8;
        run_random(80);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // fill every slot, then run past full
        write_limit(t_cnt'(CAP_SLOTS));
        repeat (CAP_SLOTS + 4) send_req(OP_ALLOC, t_slot'($urandom_range(255)));
        run_random(80);

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[bitmap_slot_allocator] OK");
        end else begin
            $display("[bitmap_slot_allocator] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/bsa_pkg.sv
rtl/core/bsa_req_if.sv
rtl/core/bsa_rsp_if.sv
rtl/core/bsa_word_eval.sv
rtl/core/bitmap_slot_allocator.sv
dv/bsa_alloc_checker.sv
dv/tb_top.sv
